>>> hdl/lrts_pkg.sv
// ----------------------------------------------------------------------------
// lrts_pkg
// Types and constants shared by the longest-remaining-time scheduler modules.
// ----------------------------------------------------------------------------
package lrts_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_ADMIT = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  job_id;
    logic [11:0] burst_len;
  } lrts_item_t;

  typedef struct packed {
    logic        ran_valid;
    logic [7:0]  ran_job;
    logic        job_done;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic        admit_rejected;
  } lrts_result_t;

  // One slot's contents; also the candidate that travels down the cell chain.
  typedef struct packed {
    logic [11:0] remaining;
    logic [7:0]  job;
    logic [11:0] burst;
    logic [31:0] arrival;
  } lrts_entry_t;

  typedef struct packed {
    logic clear;
    logic admit;
    logic dec;
  } lrts_cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_REPORT
  } lrts_state_t;

endpackage

>>> hdl/longest_remaining_time_scheduler_top.sv
// ----------------------------------------------------------------------------
// longest_remaining_time_scheduler_top
// Preemptive longest-remaining-time-first scheduler, one time unit per tick or admit command.
//
//   Channel   Handshake            Payload
//   input     start / busy         item   (cmd, job_id, burst_len)
//   result    strobe, one cycle    result (ran_valid ... admit_rejected)
//
// For a tick or admit, the best candidate walks the chain of slot cells one
// cell per cycle in the scan state; the finish state then updates the winner
// and forms the turnaround, and the report state forms the result. A clear
// command goes straight to the report state. Reset is synchronous and empties the table.
// The result is shown for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module longest_remaining_time_scheduler_top
  import lrts_pkg::*;
#(
  parameter int MAX_JOBS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  lrts_item_t   item,
  output logic         strobe,
  output lrts_result_t result
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_JOBS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_JOBS);

  lrts_state_t        state;
  lrts_state_t        state_next;
  logic [IDX_W-1:0]   scan_cnt;
  logic [31:0]        clock_now;
  logic [CNT_W-1:0]   slots_used;
  logic               is_clear;
  logic               rejected;
  logic               fin_valid;
  logic [7:0]         fin_job;
  logic               fin_done;
  logic [31:0]        fin_tat;
  logic [11:0]        fin_burst;

  logic               accept;
  logic               admit_ok;
  lrts_cell_ctl_t     cell_ctl;
  lrts_entry_t        admit_data;
  lrts_entry_t        cand [MAX_JOBS+1];
  logic [IDX_W-1:0]   cand_idx [MAX_JOBS+1];
  lrts_entry_t        win;
  logic [IDX_W-1:0]   win_idx;
  logic [31:0]        wait_val;

  assign accept   = start && !busy;
  assign admit_ok = (item.cmd == CMD_ADMIT) && (slots_used != FULL_CNT) &&
                    (item.burst_len != 12'd0);
  assign admit_data = '{remaining: item.burst_len, job: item.job_id,
                        burst: item.burst_len, arrival: clock_now};
  assign cand[0]     = '0;
  assign cand_idx[0] = '0;
  assign win         = cand[MAX_JOBS];
  assign win_idx     = cand_idx[MAX_JOBS];

  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    lrts_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (cell_ctl),
      .admit_data   (admit_data),
      .admit_idx    (slots_used[IDX_W-1:0]),
      .dec_idx      (win_idx),
      .cand_in      (cand[g]),
      .cand_idx_in  (cand_idx[g]),
      .cand_out     (cand[g+1]),
      .cand_idx_out (cand_idx[g+1])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (item.cmd == CMD_CLEAR) ? ST_REPORT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == LAST_IDX) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_REPORT;
      ST_REPORT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    cell_ctl = '0;
    case (state)
      ST_IDLE: begin
        busy           = 1'b0;
        cell_ctl.clear = start && (item.cmd == CMD_CLEAR);
        cell_ctl.admit = start && admit_ok;
      end
      ST_FINISH: begin
        cell_ctl.dec = win.remaining != 12'd0;
      end
      default: begin
        cell_ctl = '0;
      end
    endcase
  end

  assign wait_val = (fin_tat >= {20'd0, fin_burst}) ? fin_tat - {20'd0, fin_burst} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_cnt   <= '0;
      clock_now  <= '0;
      slots_used <= '0;
      is_clear   <= 1'b0;
      rejected   <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == ST_REPORT);
      if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + IDX_W'(1);
      end else begin
        scan_cnt <= '0;
      end
      if (accept) begin
        if (item.cmd == CMD_CLEAR) begin
          clock_now  <= '0;
          slots_used <= '0;
          is_clear   <= 1'b1;
          rejected   <= 1'b0;
        end else begin
          is_clear <= 1'b0;
          rejected <= (item.cmd == CMD_ADMIT) && !admit_ok;
          if (admit_ok) begin
            slots_used <= slots_used + CNT_W'(1);
          end
          if (clock_now != 32'hFFFF_FFFF) begin
            clock_now <= clock_now + 32'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      fin_valid <= win.remaining != 12'd0;
      fin_job   <= win.job;
      fin_done  <= win.remaining == 12'd1;
      fin_tat   <= clock_now - win.arrival;
      fin_burst <= win.burst;
    end
    if (state == ST_REPORT) begin
      if (is_clear) begin
        result <= '0;
      end else begin
        result.ran_valid      <= fin_valid;
        result.ran_job        <= fin_valid ? fin_job : 8'd0;
        result.job_done       <= fin_done;
        result.turnaround     <= fin_done ? fin_tat : 32'd0;
        result.waiting        <= fin_done ? wait_val : 32'd0;
        result.admit_rejected <= rejected;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !busy)
    else $error("result strobe while a transaction is in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted transaction did not make the block busy");

  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= FULL_CNT)
    else $error("slot count exceeds the table size");

  a_done_ran: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.job_done) |-> result.ran_valid)
    else $error("job reported finished without running");
`endif

endmodule

>>> hdl/lrts_cell.sv
// ----------------------------------------------------------------------------
// lrts_cell
// One job slot. Holds the slot contents and passes on the better of its own
// job and the candidate from the previous cell.
// ----------------------------------------------------------------------------
module lrts_cell
  import lrts_pkg::*;
#(
  parameter int IDX_W    = 3,
  parameter int CELL_IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lrts_cell_ctl_t       ctl,
  input  lrts_entry_t          admit_data,
  input  logic [IDX_W-1:0]     admit_idx,
  input  logic [IDX_W-1:0]     dec_idx,
  input  lrts_entry_t          cand_in,
  input  logic [IDX_W-1:0]     cand_idx_in,
  output lrts_entry_t          cand_out,
  output logic [IDX_W-1:0]     cand_idx_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [11:0] remaining;
  logic [7:0]  job;
  logic [11:0] burst;
  logic [31:0] arrival;
  logic        admit_here;
  logic        dec_here;
  logic        take_mine;

  assign admit_here = ctl.admit && (admit_idx == MY_IDX);
  assign dec_here   = ctl.dec && (dec_idx == MY_IDX);
  // Strictly greater keeps the earlier slot on a tie.
  assign take_mine  = remaining > cand_in.remaining;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      remaining <= '0;
    end else if (admit_here) begin
      remaining <= admit_data.remaining;
    end else if (dec_here) begin
      remaining <= remaining - 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (admit_here) begin
      job     <= admit_data.job;
      burst   <= admit_data.burst;
      arrival <= admit_data.arrival;
    end
  end

  always_ff @(posedge clk) begin
    if (take_mine) begin
      cand_out     <= '{remaining: remaining, job: job, burst: burst, arrival: arrival};
      cand_idx_out <= MY_IDX;
    end else begin
      cand_out     <= cand_in;
      cand_idx_out <= cand_idx_in;
    end
  end

endmodule
